// ===== rtl/rcvdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-compressed voxel delta table package
// Shared types, codes and field layout of the run table.
// ----------------------------------------------------------------------------
package rcvdt_pkg;

  localparam int unsigned LEN_W   = 10;
  localparam int unsigned BASE_W  = 48;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned LM_W    = 16;
  localparam int unsigned ENTRY_W = BASE_W + CODE_W + LM_W;
  localparam int unsigned AX_W    = 18;

  localparam logic [7:0] MISS_CODE = 8'hFF;

  localparam logic KIND_SET    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] MODE_ZERO = 2'b00;
  localparam logic [1:0] MODE_POS  = 2'b10;
  localparam logic [1:0] MODE_NEG  = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_TAIL_RD,
    ST_TAIL_WR,
    ST_SPLIT,
    ST_END,
    ST_OUT
  } state_e;

  typedef enum logic {
    RD_IDX,
    RD_TAIL
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_EVAL,
    WR_TAIL,
    WR_SPLIT,
    WR_APPEND
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_FOUND,
    RES_MISS,
    RES_FULL,
    RES_CLEAR
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     idx_clr;
    logic     idx_inc;
    logic     cnt_inc;
    logic     cnt_dec;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     res_ld;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic eq;
    logic idx_end;
    logic cnt_one;
    logic cnt_full;
    logic cov;
    logic del;
    logic trim;
    logic split;
    logic match;
    logic ext_hit;
  } stat_t;

endpackage

// ===== rtl/rcvdt_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one set or lookup item.
// ----------------------------------------------------------------------------
interface rcvdt_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] pos_x;
  logic        [7:0]  pos_y;
  logic signed [15:0] pos_z;
  logic        [7:0]  new_block;
  logic               equals_terrain;

  modport source (output valid, kind, pos_x, pos_y, pos_z, new_block, equals_terrain,
                  input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, new_block, equals_terrain,
                  output ready);
endinterface

// ===== rtl/rcvdt_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface rcvdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] found_block;
  logic       table_full;

  modport source (output valid, found_block, table_full, input ready);
  modport sink   (input valid, found_block, table_full, output ready);
endinterface

// ===== rtl/rcvdt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcvdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rcvdt_datapath.sv =====
// ----------------------------------------------------------------------------
// Run table datapath
// Run store, scan index, run count, run evaluation and result register.
// ----------------------------------------------------------------------------
module rcvdt_datapath #(
  parameter int unsigned MAX_RUNS    = 256,
  parameter int unsigned MAX_RUN_LEN = 1023
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcvdt_pkg::cmd_t     cmd_i,
  output rcvdt_pkg::stat_t    stat_o,
  input  logic                kind_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic        [7:0]   pos_y_i,
  input  logic signed [15:0]  pos_z_i,
  input  logic        [7:0]   new_block_i,
  input  logic                equals_terrain_i,
  output logic        [7:0]   found_block_o,
  output logic                table_full_o
);

  localparam int unsigned IW = $clog2(MAX_RUNS);
  localparam int unsigned CW = $clog2(MAX_RUNS + 1);
  localparam int unsigned AW = rcvdt_pkg::AX_W;
  localparam int unsigned EW = rcvdt_pkg::ENTRY_W;

  logic               kind_q;
  logic signed [15:0] px_q, pz_q;
  logic        [7:0]  py_q, blk_q;
  logic               eq_q;
  logic [CW-1:0]      idx_q, idx_d, cnt_q, cnt_d;
  logic [EW-1:0]      spl_q;
  logic [7:0]         found_q;
  logic               full_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [47:0]   r_base;
  logic [7:0]    r_code;
  logic [15:0]   r_lm;
  logic [9:0]    len;
  logic signed [AW-1:0] lenx;
  logic signed [AW-1:0] b_ax [3];
  logic signed [AW-1:0] p_ax [3];
  logic signed [AW-1:0] d_ax [3];
  logic signed [AW-1:0] ad_ax [3];
  logic signed [AW-1:0] ts_ax [3];
  logic signed [AW-1:0] sp_ax [3];
  logic [1:0]    m_ax [3];
  logic [1:0]    nm_ax [3];
  logic [2:0]    cov_ax, near_ax, endh_ax;
  logic [9:0]    li;
  logic signed [AW-1:0] li1;
  logic          cov, del, trim_s, trim_e, ext_hit;
  logic [47:0]   ts_base, sp_base, ap_base;
  logic [EW-1:0] eval_wdata, spl_d;

  assign r_base = rdata[EW-1 -: 48];
  assign r_code = rdata[15+8 -: 8];
  assign r_lm   = rdata[15:0];
  assign len    = r_lm[9:0];
  assign lenx   = AW'(len);

  assign b_ax[0] = AW'(signed'(r_base[15:0]));
  assign b_ax[1] = AW'(r_base[23:16]);
  assign b_ax[2] = AW'(signed'(r_base[47:32]));
  assign p_ax[0] = AW'(px_q);
  assign p_ax[1] = AW'(py_q);
  assign p_ax[2] = AW'(pz_q);
  assign m_ax[0] = r_lm[15:14];
  assign m_ax[1] = r_lm[13:12];
  assign m_ax[2] = r_lm[11:10];

  always_comb begin
    priority if (m_ax[0] != rcvdt_pkg::MODE_ZERO) li = ad_ax[0][9:0];
    else if (m_ax[1] != rcvdt_pkg::MODE_ZERO)     li = ad_ax[1][9:0];
    else if (m_ax[2] != rcvdt_pkg::MODE_ZERO)     li = ad_ax[2][9:0];
    else                                          li = '0;
    li1 = AW'(li) + AW'(1);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_ax[a]  = p_ax[a] - b_ax[a];
      ad_ax[a] = (m_ax[a] == rcvdt_pkg::MODE_NEG) ? -d_ax[a] : d_ax[a];
      if (m_ax[a] == rcvdt_pkg::MODE_ZERO) begin
        cov_ax[a]  = d_ax[a] == '0;
        endh_ax[a] = d_ax[a] == '0;
        ts_ax[a]   = b_ax[a];
        sp_ax[a]   = b_ax[a];
      end else if (m_ax[a] == rcvdt_pkg::MODE_NEG) begin
        cov_ax[a]  = (d_ax[a] <= 0) && (ad_ax[a] < lenx);
        endh_ax[a] = d_ax[a] == -lenx;
        ts_ax[a]   = b_ax[a] - AW'(1);
        sp_ax[a]   = b_ax[a] - li1;
      end else begin
        cov_ax[a]  = (d_ax[a] >= 0) && (ad_ax[a] < lenx);
        endh_ax[a] = d_ax[a] == lenx;
        ts_ax[a]   = b_ax[a] + AW'(1);
        sp_ax[a]   = b_ax[a] + li1;
      end
      near_ax[a] = (d_ax[a] >= -1) && (d_ax[a] <= 1);
      if (d_ax[a] == '0)     nm_ax[a] = rcvdt_pkg::MODE_ZERO;
      else if (d_ax[a] > 0)  nm_ax[a] = rcvdt_pkg::MODE_POS;
      else                   nm_ax[a] = rcvdt_pkg::MODE_NEG;
    end
  end

  assign ts_base = {ts_ax[2][15:0], 8'h00, ts_ax[1][7:0], ts_ax[0][15:0]};
  assign sp_base = {sp_ax[2][15:0], 8'h00, sp_ax[1][7:0], sp_ax[0][15:0]};
  assign ap_base = {pz_q, 8'h00, py_q, px_q};

  assign cov     = &cov_ax;
  assign del     = cov && (li == '0) && (len <= 10'd1);
  assign trim_s  = cov && !del && (li == '0);
  assign trim_e  = cov && !del && !trim_s && (li == len - 10'd1);
  assign ext_hit = (len == 10'd1) ? (&near_ax)
                                  : ((&endh_ax) && (32'(len) < MAX_RUN_LEN));

  always_comb begin
    if (trim_s) begin
      eval_wdata = {ts_base, r_code, r_lm - 16'd1};
    end else if (trim_e) begin
      eval_wdata = {r_base, r_code, r_lm - 16'd1};
    end else if (cov) begin
      eval_wdata = {r_base, r_code, r_lm[15:10], li};
    end else if (len == 10'd1) begin
      eval_wdata = {r_base, r_code, nm_ax[0], nm_ax[1], nm_ax[2], 10'd2};
    end else begin
      eval_wdata = {r_base, r_code, r_lm + 16'd1};
    end
    spl_d = {sp_base, r_code, r_lm[15:10], len - li - 10'd1};
  end

  always_comb begin
    we = cmd_i.wr_en;
    unique case (cmd_i.wr_sel)
      rcvdt_pkg::WR_EVAL: begin
        waddr = idx_q[IW-1:0];
        wdata = eval_wdata;
      end
      rcvdt_pkg::WR_TAIL: begin
        waddr = idx_q[IW-1:0];
        wdata = rdata;
      end
      rcvdt_pkg::WR_SPLIT: begin
        waddr = cnt_q[IW-1:0];
        wdata = spl_q;
      end
      default: begin
        waddr = cnt_q[IW-1:0];
        wdata = {ap_base, blk_q, 16'd1};
      end
    endcase
    raddr = (cmd_i.rd_sel == rcvdt_pkg::RD_TAIL) ? cnt_q[IW-1:0] : idx_q[IW-1:0];
  end

  rcvdt_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_RUNS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = idx_q + CW'(1);
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) cnt_d = cnt_q + CW'(1);
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      blk_q  <= new_block_i;
      eq_q   <= equals_terrain_i;
    end
    spl_q <= spl_d;
    if (cmd_i.res_ld) begin
      unique case (cmd_i.res_sel)
        rcvdt_pkg::RES_FOUND: begin
          found_q <= r_code;
          full_q  <= 1'b0;
        end
        rcvdt_pkg::RES_MISS: begin
          found_q <= rcvdt_pkg::MISS_CODE;
          full_q  <= 1'b0;
        end
        rcvdt_pkg::RES_FULL: begin
          found_q <= 8'h00;
          full_q  <= 1'b1;
        end
        default: begin
          found_q <= 8'h00;
          full_q  <= 1'b0;
        end
      endcase
    end
  end

  assign found_block_o = found_q;
  assign table_full_o  = full_q;

  always_comb begin
    stat_o           = '0;
    stat_o.is_lookup = kind_q == rcvdt_pkg::KIND_LOOKUP;
    stat_o.eq        = eq_q;
    stat_o.idx_end   = idx_q >= cnt_q;
    stat_o.cnt_one   = cnt_q == CW'(1);
    stat_o.cnt_full  = cnt_q == CW'(MAX_RUNS);
    stat_o.cov       = cov;
    stat_o.del       = del;
    stat_o.trim      = trim_s || trim_e;
    stat_o.split     = cov && !del && !trim_s && !trim_e;
    stat_o.match     = (r_code == blk_q) && !eq_q;
    stat_o.ext_hit   = ext_hit;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_RUNS) else $error("run count beyond table size");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> cnt_q != CW'(MAX_RUNS)) else $error("append into full table");
  a_cnt_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> cnt_q != '0) else $error("delete from empty table");
  a_idx_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_inc |-> idx_q < cnt_q) else $error("scan index past run count");

endmodule

// ===== rtl/rcvdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Run table controller
// Sequences the scan, cut, extend and append steps of one item.
// ----------------------------------------------------------------------------
module rcvdt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rcvdt_pkg::stat_t   stat_i,
  output rcvdt_pkg::cmd_t    cmd_o
);

  rcvdt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcvdt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rcvdt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = rcvdt_pkg::ST_READ;
        end
      end
      rcvdt_pkg::ST_READ: begin
        state_d = stat_i.idx_end ? rcvdt_pkg::ST_END : rcvdt_pkg::ST_EVAL;
      end
      rcvdt_pkg::ST_EVAL: begin
        if (stat_i.is_lookup) begin
          if (stat_i.cov) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = rcvdt_pkg::RES_FOUND;
            state_d       = rcvdt_pkg::ST_OUT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = rcvdt_pkg::ST_READ;
          end
        end else if (stat_i.del) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = stat_i.cnt_one ? rcvdt_pkg::ST_END : rcvdt_pkg::ST_TAIL_RD;
        end else if (stat_i.trim) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = rcvdt_pkg::WR_EVAL;
          cmd_o.idx_inc = 1'b1;
          state_d       = rcvdt_pkg::ST_READ;
        end else if (stat_i.split) begin
          if (stat_i.cnt_full) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = rcvdt_pkg::RES_FULL;
            state_d       = rcvdt_pkg::ST_OUT;
          end else begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = rcvdt_pkg::WR_EVAL;
            state_d      = rcvdt_pkg::ST_SPLIT;
          end
        end else if (stat_i.match && stat_i.ext_hit) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = rcvdt_pkg::WR_EVAL;
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = rcvdt_pkg::RES_CLEAR;
          state_d       = rcvdt_pkg::ST_OUT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = rcvdt_pkg::ST_READ;
        end
      end
      rcvdt_pkg::ST_TAIL_RD: begin
        cmd_o.rd_sel = rcvdt_pkg::RD_TAIL;
        state_d      = rcvdt_pkg::ST_TAIL_WR;
      end
      rcvdt_pkg::ST_TAIL_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = rcvdt_pkg::WR_TAIL;
        state_d      = rcvdt_pkg::ST_READ;
      end
      rcvdt_pkg::ST_SPLIT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = rcvdt_pkg::WR_SPLIT;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = rcvdt_pkg::ST_READ;
      end
      rcvdt_pkg::ST_END: begin
        cmd_o.res_ld = 1'b1;
        state_d      = rcvdt_pkg::ST_OUT;
        if (stat_i.is_lookup) begin
          cmd_o.res_sel = rcvdt_pkg::RES_MISS;
        end else if (stat_i.eq) begin
          cmd_o.res_sel = rcvdt_pkg::RES_CLEAR;
        end else if (stat_i.cnt_full) begin
          cmd_o.res_sel = rcvdt_pkg::RES_FULL;
        end else begin
          cmd_o.res_sel = rcvdt_pkg::RES_CLEAR;
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = rcvdt_pkg::WR_APPEND;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      rcvdt_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = rcvdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcvdt_pkg::ST_IDLE;
      end
    endcase
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcvdt_pkg::ST_OUT && !out_ready_i) |=> state_q == rcvdt_pkg::ST_OUT)
    else $error("result dropped before taken");
  a_wr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcvdt_pkg::ST_TAIL_WR) |-> $past(cmd_o.rd_sel) == rcvdt_pkg::RD_TAIL)
    else $error("tail copy without tail read");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == rcvdt_pkg::ST_IDLE) else $error("item taken while busy");

endmodule

// ===== rtl/run_compressed_voxel_delta_table_top.sv =====
// ----------------------------------------------------------------------------
// Run-compressed voxel delta table
// Table of runs of changed voxels with set and lookup items.
// ----------------------------------------------------------------------------
// One item at a time. Each item scans the stored runs in order, with a read
// state and an evaluate state per run, as the single-read-port run store has
// registered read data; a lookup ends early when a covering run is found. A
// set runs the same scan plus a tail read and write for each run deleted and
// a split write for each run split. An append is written in the end state
// after the scan; an extension ends the scan at once. The result is held
// until taken, then the next item is accepted. No clearing pass after reset.
module run_compressed_voxel_delta_table_top #(
  parameter int unsigned MAX_RUNS    = 256,
  parameter int unsigned MAX_RUN_LEN = 1023
) (
  input logic           clk_i,
  input logic           rst_ni,
  rcvdt_in_if.sink      in_if,
  rcvdt_out_if.source   out_if
);

  rcvdt_pkg::cmd_t  cmd;
  rcvdt_pkg::stat_t stat;

  rcvdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rcvdt_datapath #(
    .MAX_RUNS   (MAX_RUNS),
    .MAX_RUN_LEN(MAX_RUN_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (in_if.kind),
    .pos_x_i         (in_if.pos_x),
    .pos_y_i         (in_if.pos_y),
    .pos_z_i         (in_if.pos_z),
    .new_block_i     (in_if.new_block),
    .equals_terrain_i(in_if.equals_terrain),
    .found_block_o   (out_if.found_block),
    .table_full_o    (out_if.table_full)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Run-compressed voxel delta table testbench
// Drives set and lookup items through the request channel with random gaps
// and result back-pressure, predicts every result with a behavioural copy of
// the run table and compares each result item field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NRUNS   = 256;
  localparam int unsigned RUNMAX  = 1023;
  localparam int          N_RAND  = 440;
  localparam int          WD_LIM  = 200000;

  typedef struct packed {
    logic       kind;
    logic [15:0] x;
    logic [7:0] y;
    logic [15:0] z;
    logic [7:0] blk;
    logic       eq;
  } voxel_req_t;

  typedef struct packed {
    logic [7:0] found;
    logic       full;
  } voxel_res_t;

  typedef struct {
    voxel_req_t req;
    logic       has_exp;
    voxel_res_t exp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rcvdt_in_if  req_ch();
  rcvdt_out_if res_ch();

  run_compressed_voxel_delta_table_top #(.MAX_RUNS(NRUNS), .MAX_RUN_LEN(RUNMAX)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch.sink),
    .out_if (res_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow run table
  logic [47:0] sh_base [NRUNS];
  logic [7:0]  sh_code [NRUNS];
  logic [15:0] sh_lm   [NRUNS];
  int unsigned sh_count;

  voxel_res_t  pending_res[$];
  int          n_err, n_sets, n_looks, n_full, n_miss, wd_cnt, res_gap;
  bit          quiet_tail, long_hold;

  function automatic int sx16(logic [15:0] v);
    return int'(signed'(v));
  endfunction

  function automatic int axis_step(logic [1:0] m);
    if (m == rcvdt_pkg::MODE_ZERO) return 0;
    return (m == rcvdt_pkg::MODE_NEG) ? -1 : 1;
  endfunction

  function automatic logic [1:0] off_mode(int o);
    if (o == 0) return rcvdt_pkg::MODE_ZERO;
    return (o > 0) ? rcvdt_pkg::MODE_POS : rcvdt_pkg::MODE_NEG;
  endfunction

  function automatic bit axis_cov(logic [1:0] m, int b, int len, int v);
    if (m == rcvdt_pkg::MODE_ZERO) return b == v;
    if (m == rcvdt_pkg::MODE_NEG) return b >= v && b - len < v;
    return b <= v && b + len > v;
  endfunction

  function automatic logic [47:0] base_of(int x, int y, int z);
    logic [47:0] r;
    r = '0;
    r[15:0] = x[15:0];
    r[23:16] = y[7:0];
    r[47:32] = z[15:0];
    return r;
  endfunction

  function automatic bit run_hit(int unsigned i, int px, int py, int pz);
    int len;
    len = int'(sh_lm[i][9:0]);
    return axis_cov(sh_lm[i][15:14], sx16(sh_base[i][15:0]), len, px)
        && axis_cov(sh_lm[i][13:12], int'(sh_base[i][23:16]), len, py)
        && axis_cov(sh_lm[i][11:10], sx16(sh_base[i][47:32]), len, pz);
  endfunction

  function automatic logic place_voxel(int px, int py, int pz, logic [7:0] blk, logic eq);
    int unsigned i;
    int len, bx, by, bz, sx, sy, sz, li, ox, oy, oz;
    logic [15:0] lm, modes;
    i = 0;
    while (i < sh_count) begin
      lm = sh_lm[i];
      modes = lm & 16'hFC00;
      len = int'(lm[9:0]);
      bx = sx16(sh_base[i][15:0]);
      by = int'(sh_base[i][23:16]);
      bz = sx16(sh_base[i][47:32]);
      sx = axis_step(lm[15:14]);
      sy = axis_step(lm[13:12]);
      sz = axis_step(lm[11:10]);
      if (run_hit(i, px, py, pz)) begin
        li = 0;
        if (lm[15:14] != rcvdt_pkg::MODE_ZERO) li = (px - bx) * sx;
        else if (lm[13:12] != rcvdt_pkg::MODE_ZERO) li = (py - by) * sy;
        else if (lm[11:10] != rcvdt_pkg::MODE_ZERO) li = (pz - bz) * sz;
        if (li == 0) begin
          if (len <= 1) begin
            sh_count--;
            if (sh_count == 0) break;
            sh_base[i] = sh_base[sh_count];
            sh_code[i] = sh_code[sh_count];
            sh_lm[i] = sh_lm[sh_count];
            continue;
          end
          sh_base[i] = base_of(bx + sx, by + sy, bz + sz);
          sh_lm[i] = lm - 16'd1;
          i++;
          continue;
        end else if (li == len - 1) begin
          sh_lm[i] = lm - 16'd1;
          i++;
          continue;
        end else begin
          if (sh_count >= NRUNS) return 1'b1;
          sh_lm[i] = modes | (16'(li) & 16'h3FF);
          sh_base[sh_count] = base_of(bx + sx*(li+1), by + sy*(li+1), bz + sz*(li+1));
          sh_code[sh_count] = sh_code[i];
          sh_lm[sh_count] = modes | (16'(len - li - 1) & 16'h3FF);
          sh_count++;
        end
      end
      if (sh_code[i] != blk || eq) begin
        i++;
        continue;
      end
      if (len == 1) begin
        ox = px - bx; oy = py - by; oz = pz - bz;
        if (ox >= -1 && ox <= 1 && oy >= -1 && oy <= 1 && oz >= -1 && oz <= 1) begin
          sh_lm[i] = {off_mode(ox), off_mode(oy), off_mode(oz), 10'd2};
          return 1'b0;
        end
      end else if (bx + sx*len == px && by + sy*len == py && bz + sz*len == pz) begin
        if (len >= RUNMAX) begin
          i++;
          continue;
        end
        sh_lm[i] = sh_lm[i] + 16'd1;
        return 1'b0;
      end
      i++;
    end
    if (eq) return 1'b0;
    if (sh_count >= NRUNS) return 1'b1;
    sh_base[sh_count] = base_of(px, py, pz);
    sh_code[sh_count] = blk;
    sh_lm[sh_count] = 16'd1;
    sh_count++;
    return 1'b0;
  endfunction

  function automatic voxel_res_t apply_voxel_req(voxel_req_t r);
    voxel_res_t o;
    int px, py, pz;
    px = sx16(r.x); py = int'(r.y); pz = sx16(r.z);
    o = '0;
    if (r.kind == rcvdt_pkg::KIND_LOOKUP) begin
      o.found = rcvdt_pkg::MISS_CODE;
      for (int unsigned i = 0; i < sh_count; i++)
        if (run_hit(i, px, py, pz)) begin
          o.found = sh_code[i];
          break;
        end
    end else begin
      o.full = place_voxel(px, py, pz, r.blk, r.eq);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    n_err++;
  endtask

  task automatic send_voxel_req(voxel_req_t r);
    voxel_res_t p;
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    req_ch.pos_x <= r.x;
    req_ch.pos_y <= r.y;
    req_ch.pos_z <= r.z;
    req_ch.new_block <= r.blk;
    req_ch.equals_terrain <= r.eq;
    do @(posedge clk_i); while (!req_ch.ready);
    p = apply_voxel_req(r);
    pending_res.push_back(p);
    if (r.kind == rcvdt_pkg::KIND_LOOKUP) begin
      n_looks++;
      if (p.found == rcvdt_pkg::MISS_CODE) n_miss++;
    end else begin
      n_sets++;
      if (p.full) n_full++;
    end
  endtask

  function automatic voxel_req_t mk_req(logic k, int x, int y, int z, int b, logic e);
    voxel_req_t r;
    r.kind = k; r.x = x[15:0]; r.y = y[7:0]; r.z = z[15:0]; r.blk = b[7:0]; r.eq = e;
    return r;
  endfunction

  // result side: random stall bursts, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      res_gap = 0;
    end else if (long_hold) begin
      res_ch.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_ch.ready <= 1'b0;
      res_gap--;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      res_gap = $urandom_range(0, 14);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        voxel_res_t e;
        e = pending_res.pop_front();
        if (res_ch.found_block !== e.found)
          report_mismatch("found_block", res_ch.found_block, e.found);
        if (res_ch.table_full !== e.full)
          report_mismatch("table_full", res_ch.table_full, e.full);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) wd_cnt = 0;
    else wd_cnt++;
    if (wd_cnt >= WD_LIM) begin
      $display("watchdog expired at %0t", $time);
      $display("FAIL run_compressed_voxel_delta_table_top");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    voxel_req_t r;
    int bx, by, bz, ln, dx, dy, dz, drain;
    req_ch.valid = 1'b0;
    req_ch.kind = rcvdt_pkg::KIND_SET;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_z = '0;
    req_ch.new_block = '0;
    req_ch.equals_terrain = 1'b0;
    sh_count = 0;
    n_err = 0; wd_cnt = 0;
    quiet_tail = 0; long_hold = 0;

    dir_tab = '{
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, 0, 0, 0, 0, 1'b0), 1'b1,
        '{rcvdt_pkg::MISS_CODE, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, -32768, 255, 32767, 255, 1'b1), 1'b1,
        '{rcvdt_pkg::MISS_CODE, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 0, 0, 0, 7, 1'b0), 1'b1, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, 0, 0, 0, 0, 1'b0), 1'b1, '{8'd7, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 1, 0, 0, 7, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 2, 0, 0, 7, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 3, 0, 0, 7, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 4, 0, 0, 7, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 2, 0, 0, 9, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 0, 0, 0, 3, 1'b1), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 4, 0, 0, 3, 1'b1), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, 2, 0, 0, 0, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, 0, 0, 0, 0, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 32767, 255, -32768, 255, 1'b0), 1'b1, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 32766, 254, -32767, 255, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, 32765, 253, -32766, 255, 1'b0), 1'b0, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, 32766, 254, -32767, 0, 1'b0), 1'b1,
        '{8'd255, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, -32768, 0, 32767, 0, 1'b0), 1'b1, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, -32768, 0, 32767, 0, 1'b0), 1'b1, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_SET, -32768, 0, 32767, 0, 1'b1), 1'b1, '{8'd0, 1'b0}},
      '{mk_req(rcvdt_pkg::KIND_LOOKUP, -32768, 0, 32767, 0, 1'b0), 1'b0, '{8'd0, 1'b0}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      send_voxel_req(dir_tab[k].req);
      if (dir_tab[k].has_exp && pending_res[$] != dir_tab[k].exp)
        report_mismatch("directed row prediction", k, -1);
    end

    // a long run along one axis, split in the middle, then erased
    bx = $urandom_range(0, 65535) - 32768;
    for (int k = 0; k < 60; k++)
      send_voxel_req(mk_req(rcvdt_pkg::KIND_SET, bx + k, 10, 5, 42, 1'b0));
    send_voxel_req(mk_req(rcvdt_pkg::KIND_SET, bx + 30, 10, 5, 1, 1'b0));
    send_voxel_req(mk_req(rcvdt_pkg::KIND_LOOKUP, bx + 59, 10, 5, 0, 1'b0));
    for (int k = 0; k < 62; k++)
      send_voxel_req(mk_req(rcvdt_pkg::KIND_SET, bx + k, 10, 5, 42, 1'b1));

    // fill the table to force full reports, receiver held off at the start
    fork
      begin
        long_hold = 1;
        repeat (400) @(posedge clk_i);
        long_hold = 0;
      end
    join_none
    for (int k = 0; k < 262; k++)
      send_voxel_req(mk_req(rcvdt_pkg::KIND_SET, 3 * k, 100, -3 * k, k, 1'b0));
    send_voxel_req(mk_req(rcvdt_pkg::KIND_SET, 3, 100, -3, 1, 1'b0));
    send_voxel_req(mk_req(rcvdt_pkg::KIND_LOOKUP, 0, 100, 0, 0, 1'b0));

    // random part: runs in a small region with random direction, plus noise
    for (int k = 0; k < N_RAND; k++) begin
      if (k > N_RAND - 100) quiet_tail = 1;
      if ($urandom_range(0, 9) < 7) begin
        bx = $urandom_range(0, 15) - 8;
        by = $urandom_range(0, 15);
        bz = $urandom_range(0, 15) - 8;
        dx = $urandom_range(0, 2) - 1;
        dy = $urandom_range(0, 2) - 1;
        dz = $urandom_range(0, 2) - 1;
        ln = $urandom_range(1, 6);
        for (int j = 0; j < ln; j++) begin
          r = mk_req($urandom_range(0, 4) == 0, bx + dx*j, by + dy*j, bz + dz*j,
                     $urandom_range(0, 3), $urandom_range(0, 7) == 0);
          send_voxel_req(r);
        end
        k += ln - 1;
      end else begin
        r = voxel_req_t'(50'({$urandom(), $urandom()}));
        send_voxel_req(r);
      end
    end

    req_ch.valid <= 1'b0;
    drain = 0;
    while (pending_res.size() != 0 && drain < WD_LIM) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * NRUNS + 20) @(posedge clk_i);
    $display("covered %0d sets (%0d table full) and %0d lookups (%0d misses)",
             n_sets, n_full, n_looks, n_miss);
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("PASS run_compressed_voxel_delta_table_top");
    end else begin
      $display("FAIL run_compressed_voxel_delta_table_top");
    end
    $finish;
  end

endmodule
